[rtl/core/lst_pkg.sv]
// Package for the peer link statistics table: sizes, codes, shared types.
// Depends on nothing; used by every module under rtl/core.
package lst_pkg;

  localparam int PEERS       = 16;
  localparam int EWMA_SCALE  = 100;
  localparam int ETX_DIVISOR = 128;
  localparam int RING_DEPTH  = 4;

  localparam int IDX_W   = (PEERS > 1) ? $clog2(PEERS) : 1;
  localparam int CNT_W   = $clog2(PEERS + 1);
  localparam int ENT_W   = $clog2(PEERS + 1);
  localparam int RP_W    = $clog2(RING_DEPTH);
  localparam int SCALE_W = $clog2(EWMA_SCALE + 1);
  localparam int ALPHA_W = 7;
  localparam int WCMP_W  = (ALPHA_W > SCALE_W) ? ALPHA_W : SCALE_W;
  localparam int SUM_W   = 16 + SCALE_W;
  localparam int ENTRY_W = 4;

  // Reciprocal of the scale, rounded up, exact for every weighted sum
  localparam int     REC_SH = SUM_W + SCALE_W;
  localparam longint REC_M  = ((64'd1 << REC_SH) + EWMA_SCALE - 1) / EWMA_SCALE;
  localparam int     REC_W  = $clog2(REC_M + 1);
  localparam int     PROD_W = SUM_W + REC_W;

  // Event kinds
  localparam logic [1:0] KIND_RECORD = 2'd0;
  localparam logic [1:0] KIND_TXSTAT = 2'd1;
  localparam logic [1:0] KIND_RX     = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_ALPHA   = 2'd0;
  localparam logic [1:0] REG_ETX_INI = 2'd1;
  localparam logic [1:0] REG_PENALTY = 2'd2;

  typedef enum logic [1:0] {
    ST_EXISTING = 2'd0,
    ST_NEW      = 2'd1,
    ST_FULL     = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_KEY, S_RD, S_RDW, S_OP, S_E1W, S_E2W, S_DONE
  } state_t;

  typedef struct packed {
    logic             done;
    status_t          status;
    logic [IDX_W-1:0] slot;
  } key_res_t;

  typedef struct packed {
    logic [15:0] etx;
    logic [7:0]  rssi;
    logic [7:0]  lqi;
    logic [31:0] rx;
    logic [31:0] tx;
    logic [31:0] fail;
  } stat_rec_t;

endpackage

[rtl/core/peer_link_stats_table_core.sv]
// Top level of the peer link statistics table: sequencer, statistics memory,
// pending ring. Depends on lst_pkg, lst_keys and lst_ewma.
//
//  channel | direction | handshake             | words
//  in      | input     | in_valid / in_ready   | one event
//  out     | output    | out_valid / out_ready | one result per event
//  cfg     | input     | cfg_valid / cfg_ready | register index and data
//
// One event at a time. A lookup scans the key memory, one used entry after
// another; the statistics memory read is registered; each moving average is
// a weighted sum, then a reciprocal multiply, run once for transmit status
// with a nonzero count, twice for a receive report after the first. Reset
// clears all entries via the fill count. A waiting result holds only the
// final step; the next word is taken meanwhile. Configuration is always ready.
module peer_link_stats_table_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [63:0] peer_address,
  input  logic [3:0]  addr_length,
  input  logic [5:0]  success_count,
  input  logic [5:0]  failure_count,
  input  logic [7:0]  rssi,
  input  logic [7:0]  lqi,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [3:0]  entry_index,
  output logic [15:0] etx_value,
  output logic [7:0]  avg_rssi,
  output logic [7:0]  avg_lqi,
  output logic [31:0] rx_total,
  output logic [31:0] tx_total,
  output logic [31:0] tx_fail_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  lst_pkg::state_t             state, state_next;
  lst_pkg::status_t            st;
  lst_pkg::key_res_t           key_res;
  lst_pkg::stat_rec_t          rec, stat_q, init_rec;
  lst_pkg::stat_rec_t          stats [lst_pkg::PEERS];

  logic [6:0]                  ewma_alpha;
  logic [4:0]                  etx_initial;
  logic [4:0]                  noack_penalty;

  logic [1:0]                  kind_r;
  logic [63:0]                 addr_r;
  logic [3:0]                  len_r;
  logic [5:0]                  succ_r, fail_r;
  logic [7:0]                  rssi_r, lqi_r;

  logic [lst_pkg::IDX_W-1:0]   slot;
  logic                        is_new;
  logic [lst_pkg::ENT_W-1:0]   ring [lst_pkg::RING_DEPTH];
  logic [lst_pkg::RP_W-1:0]    wp, rp;
  logic [lst_pkg::ENT_W-1:0]   pop_ent;
  logic                        pop_ok;
  logic                        push_en;
  logic [lst_pkg::ENT_W-1:0]   push_val;
  logic                        pop_en;

  logic                        key_start;
  logic                        ew_start;
  logic                        ew_done;
  logic [15:0]                 ew_old, ew_sample, ew_res;
  logic [16:0]                 etx_sample;
  logic [lst_pkg::SCALE_W-1:0] wt;
  logic                        stat_rd, stat_we, out_load;
  logic                        out_free;
  logic                        has_entry;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == lst_pkg::S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign has_entry = (st == lst_pkg::ST_EXISTING) || (st == lst_pkg::ST_NEW);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ewma_alpha    <= 7'd15;
      etx_initial   <= 5'd2;
      noack_penalty <= 5'd6;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lst_pkg::REG_ALPHA:   ewma_alpha    <= cfg_data;
        lst_pkg::REG_ETX_INI: etx_initial   <= cfg_data[4:0];
        lst_pkg::REG_PENALTY: noack_penalty <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // weight saturated to the scale
  assign wt = (lst_pkg::WCMP_W'(ewma_alpha) > lst_pkg::WCMP_W'(lst_pkg::EWMA_SCALE)) ?
              lst_pkg::SCALE_W'(lst_pkg::EWMA_SCALE) : lst_pkg::SCALE_W'(ewma_alpha);

  // record of a freshly claimed entry
  always_comb begin
    init_rec      = '0;
    init_rec.etx  = 16'(21'(etx_initial) * 21'(lst_pkg::ETX_DIVISOR));
  end

  // ETX sample: penalty when nothing succeeded, else twice one more than the failures
  assign etx_sample = (succ_r == 6'd0) ?
                      17'(noack_penalty) * 17'(lst_pkg::ETX_DIVISOR) :
                      (17'(fail_r) + 17'd1) * 17'(2 * lst_pkg::ETX_DIVISOR);

  // pending ring head
  assign pop_ent = ring[rp];
  assign pop_ok  = (pop_ent != '0) && (pop_ent <= lst_pkg::ENT_W'(lst_pkg::PEERS));

  lst_keys u_keys (
    .clk   (clk),
    .rst   (rst),
    .start (key_start),
    .addr  (addr_r),
    .len   (len_r),
    .res   (key_res)
  );

  lst_ewma u_ewma (
    .clk       (clk),
    .rst       (rst),
    .start     (ew_start),
    .old_value (ew_old),
    .sample    (ew_sample),
    .wt        (wt),
    .done      (ew_done),
    .result    (ew_res)
  );

  // sequencer next state and strobes
  always_comb begin
    state_next = state;
    key_start  = 1'b0;
    ew_start   = 1'b0;
    ew_old     = rec.etx;
    ew_sample  = etx_sample[15:0];
    stat_rd    = 1'b0;
    stat_we    = 1'b0;
    out_load   = 1'b0;
    push_en    = 1'b0;
    push_val   = '0;
    pop_en     = 1'b0;
    case (state)
      lst_pkg::S_IDLE: begin
        if (in_valid) state_next = lst_pkg::S_DISP;
      end
      lst_pkg::S_DISP: begin
        case (kind_r)
          lst_pkg::KIND_RECORD: begin
            if (len_r == 4'd0) begin
              push_en    = 1'b1;
              state_next = lst_pkg::S_DONE;
            end else begin
              key_start  = 1'b1;
              state_next = lst_pkg::S_KEY;
            end
          end
          lst_pkg::KIND_TXSTAT: begin
            pop_en     = 1'b1;
            state_next = pop_ok ? lst_pkg::S_RD : lst_pkg::S_DONE;
          end
          lst_pkg::KIND_RX: begin
            if (len_r == 4'd0) begin
              state_next = lst_pkg::S_DONE;
            end else begin
              key_start  = 1'b1;
              state_next = lst_pkg::S_KEY;
            end
          end
          default: state_next = lst_pkg::S_DONE;
        endcase
      end
      lst_pkg::S_KEY: begin
        if (key_res.done) begin
          if (kind_r == lst_pkg::KIND_RECORD) begin
            push_en = 1'b1;
            if (key_res.status != lst_pkg::ST_FULL)
              push_val = lst_pkg::ENT_W'(key_res.slot) + 1'b1;
          end
          state_next = (key_res.status == lst_pkg::ST_FULL) ? lst_pkg::S_DONE : lst_pkg::S_RD;
        end
      end
      lst_pkg::S_RD: begin
        stat_rd    = 1'b1;
        state_next = lst_pkg::S_RDW;
      end
      lst_pkg::S_RDW: state_next = lst_pkg::S_OP;
      lst_pkg::S_OP: begin
        state_next = lst_pkg::S_DONE;
        if (kind_r == lst_pkg::KIND_TXSTAT) begin
          if ((succ_r != 6'd0) || (fail_r != 6'd0)) begin
            ew_start   = 1'b1;
            state_next = lst_pkg::S_E1W;
          end
        end else if (kind_r == lst_pkg::KIND_RX) begin
          if (rec.rx != 32'd0) begin
            ew_old     = 16'(rec.rssi);
            ew_sample  = 16'(rssi_r);
            ew_start   = 1'b1;
            state_next = lst_pkg::S_E1W;
          end
        end
      end
      lst_pkg::S_E1W: begin
        if (ew_done) begin
          if (kind_r == lst_pkg::KIND_RX) begin
            ew_old     = 16'(rec.lqi);
            ew_sample  = 16'(lqi_r);
            ew_start   = 1'b1;
            state_next = lst_pkg::S_E2W;
          end else begin
            state_next = lst_pkg::S_DONE;
          end
        end
      end
      lst_pkg::S_E2W: begin
        if (ew_done) state_next = lst_pkg::S_DONE;
      end
      lst_pkg::S_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          stat_we    = has_entry;
          state_next = lst_pkg::S_IDLE;
        end
      end
      default: state_next = lst_pkg::S_IDLE;
    endcase
  end

  // control state: sequencer, ring, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lst_pkg::S_IDLE;
      wp        <= '0;
      rp        <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < lst_pkg::RING_DEPTH; i++) ring[i] <= '0;
    end else begin
      state <= state_next;
      if (push_en) begin
        ring[wp] <= push_val;
        wp       <= (wp == lst_pkg::RP_W'(lst_pkg::RING_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop_en)
        rp <= (rp == lst_pkg::RP_W'(lst_pkg::RING_DEPTH - 1)) ? '0 : rp + 1'b1;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // statistics memory, registered read
  always_ff @(posedge clk) begin
    if (stat_rd) stat_q <= stats[slot];
    if (stat_we) stats[slot] <= rec;
  end

  // working registers of the current event
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r <= kind;
      addr_r <= peer_address;
      len_r  <= addr_length;
      succ_r <= success_count;
      fail_r <= failure_count;
      rssi_r <= rssi;
      lqi_r  <= lqi;
    end
    case (state)
      lst_pkg::S_DISP: begin
        is_new <= 1'b0;
        st     <= ((kind_r == lst_pkg::KIND_TXSTAT) && pop_ok) ?
                  lst_pkg::ST_EXISTING : lst_pkg::ST_NONE;
        if ((kind_r == lst_pkg::KIND_TXSTAT) && pop_ok)
          slot <= lst_pkg::IDX_W'(pop_ent - 1'b1);
      end
      lst_pkg::S_KEY: begin
        if (key_res.done) begin
          st     <= key_res.status;
          slot   <= key_res.slot;
          is_new <= (key_res.status == lst_pkg::ST_NEW);
        end
      end
      lst_pkg::S_RDW: rec <= is_new ? init_rec : stat_q;
      lst_pkg::S_OP: begin
        if (kind_r == lst_pkg::KIND_TXSTAT) begin
          rec.tx   <= rec.tx + 32'(succ_r) + 32'(fail_r);
          rec.fail <= rec.fail + 32'(fail_r);
        end else if ((kind_r == lst_pkg::KIND_RX) && (rec.rx == 32'd0)) begin
          rec.rssi <= rssi_r;
          rec.lqi  <= lqi_r;
          rec.rx   <= 32'd1;
        end
      end
      lst_pkg::S_E1W: begin
        if (ew_done) begin
          if (kind_r == lst_pkg::KIND_RX) rec.rssi <= ew_res[7:0];
          else rec.etx <= ew_res;
        end
      end
      lst_pkg::S_E2W: begin
        if (ew_done) begin
          rec.lqi <= ew_res[7:0];
          rec.rx  <= rec.rx + 32'd1;
        end
      end
      default: ;
    endcase
    // result word, entry fields zero when no entry was used
    if (out_load) begin
      status        <= st;
      entry_index   <= has_entry ? lst_pkg::ENTRY_W'(slot) : '0;
      etx_value     <= has_entry ? rec.etx  : '0;
      avg_rssi      <= has_entry ? rec.rssi : '0;
      avg_lqi       <= has_entry ? rec.lqi  : '0;
      rx_total      <= has_entry ? rec.rx   : '0;
      tx_total      <= has_entry ? rec.tx   : '0;
      tx_fail_total <= has_entry ? rec.fail : '0;
    end
  end

`ifndef ASSERT_OFF
  a_key_done_in_key: assert property (@(posedge clk) disable iff (rst)
    key_res.done |-> state == lst_pkg::S_KEY)
    else $error("key search finished outside a lookup");

  a_ewma_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    ew_done |-> (state == lst_pkg::S_E1W || state == lst_pkg::S_E2W))
    else $error("average finished outside a wait state");

  a_no_entry_zero: assert property (@(posedge clk) disable iff (rst)
    out_load && !has_entry |=> entry_index == '0 && tx_total == '0 && etx_value == '0)
    else $error("result without entry carries entry fields");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("result loaded over a waiting word");
`endif

endmodule

[rtl/core/lst_keys.sv]
// Address key memory with a fill count and a sequential match scan.
// Depends on lst_pkg.
module lst_keys (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [63:0]         addr,
  input  logic [3:0]          len,
  output lst_pkg::key_res_t   res
);

  logic [67:0]                 keys [lst_pkg::PEERS];
  logic [67:0]                 key_q;
  logic                        busy;
  logic                        pend;
  logic [lst_pkg::CNT_W-1:0]   iss;
  logic [lst_pkg::CNT_W-1:0]   fill;
  logic [lst_pkg::IDX_W-1:0]   pidx;
  logic [63:0]                 mask;
  logic                        match;
  logic                        miss;
  logic                        issue;
  logic                        claim;
  logic                        has_room;

  // byte mask of the requested length, all bytes from eight up
  always_comb begin
    if (len >= 4'd8) mask = '1;
    else mask = (64'd1 << {len[2:0], 3'b000}) - 64'd1;
  end

  assign match    = pend && (key_q[67:64] == len) && (((key_q[63:0] ^ addr) & mask) == 64'd0);
  assign miss     = busy && !pend && (iss == fill);
  assign issue    = busy && (iss < fill);
  assign has_room = fill < lst_pkg::CNT_W'(lst_pkg::PEERS);
  assign claim    = miss && has_room;

  // key memory: one read port for the scan, one write port for a claim
  always_ff @(posedge clk) begin
    if (issue) key_q <= keys[iss[lst_pkg::IDX_W-1:0]];
    if (claim) keys[fill[lst_pkg::IDX_W-1:0]] <= {len, addr & mask};
  end

  // scan control, entries below the fill count are in use
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      pend     <= 1'b0;
      fill     <= '0;
      iss      <= '0;
      res.done <= 1'b0;
    end else begin
      res.done <= busy && !start && (match || miss);
      if (start) begin
        busy <= 1'b1;
        pend <= 1'b0;
        iss  <= '0;
      end else if (busy) begin
        pend <= issue && !match;
        pidx <= iss[lst_pkg::IDX_W-1:0];
        if (issue) iss <= iss + 1'b1;
        if (match) begin
          busy       <= 1'b0;
          res.status <= lst_pkg::ST_EXISTING;
          res.slot   <= pidx;
        end else if (miss) begin
          busy <= 1'b0;
          if (has_room) begin
            res.status <= lst_pkg::ST_NEW;
            res.slot   <= fill[lst_pkg::IDX_W-1:0];
            fill       <= fill + 1'b1;
          end else begin
            res.status <= lst_pkg::ST_FULL;
            res.slot   <= '0;
          end
        end
      end
    end
  end

endmodule

[rtl/core/lst_ewma.sv]
// Moving average unit: a registered weighted sum, then a multiply by the
// reciprocal of the scale in the next cycle. Depends on lst_pkg.
module lst_ewma (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [15:0]                 old_value,
  input  logic [15:0]                 sample,
  input  logic [lst_pkg::SCALE_W-1:0] wt,
  output logic                        done,
  output logic [15:0]                 result
);

  logic [lst_pkg::SUM_W-1:0]   sum;
  logic [lst_pkg::SUM_W-1:0]   sum_q;
  logic [lst_pkg::PROD_W-1:0]  prod;
  logic                        busy;

  assign sum = lst_pkg::SUM_W'(old_value) *
               lst_pkg::SUM_W'(lst_pkg::SCALE_W'(lst_pkg::EWMA_SCALE) - wt) +
               lst_pkg::SUM_W'(sample) * lst_pkg::SUM_W'(wt);

  // divide by the scale: rounded-up reciprocal, keep the high bits
  assign prod = lst_pkg::PROD_W'(sum_q) * lst_pkg::PROD_W'(lst_pkg::REC_M);

  always_ff @(posedge clk) begin
    if (start) sum_q <= sum;
    if (busy) result <= prod[lst_pkg::REC_SH +: 16];
  end

  // two-stage pipe control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
    end
  end

endmodule
